// ===== hdl/arrl_pkg.sv =====
// Shared constants and codes for the angular rate ramp limiter.
`default_nettype none
package arrl_pkg;

   localparam int MODE_WIDTH      = 2;
   localparam int TIME_WIDTH      = 16;
   localparam int LIMIT_WIDTH     = 17;
   localparam int HEADING_WIDTH   = 15;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 17;

   localparam logic [MODE_WIDTH-1:0] MODE_RAMP    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_RESTART = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_HOLD    = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_RATE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ACCEL    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_HEADING = 2'd2;

   localparam logic [LIMIT_WIDTH-1:0]   MAX_RATE_RESET     = 17'd12868;
   localparam logic [LIMIT_WIDTH-1:0]   MAX_ACCEL_RESET    = 17'd25736;
   localparam logic [HEADING_WIDTH-1:0] INIT_HEADING_RESET = 15'd0;

   // pi and 2*pi in Q5.12
   localparam int PI_Q     = 12868;
   localparam int TWO_PI_Q = 25736;

endpackage
`default_nettype wire

// ===== hdl/angular_rate_ramp_limiter_core.sv =====
// Ramp tick: an accepted transaction passes through S_INC, S_RAMP, S_HMUL, S_HEAD and S_DONE before its result
// is loaded into the output register; restart, hold and the spare mode code go straight to S_DONE.
// A ramp tick makes two passes through the one shared multiplier
// (accel * time, then rate * time), each followed by its ramp or heading update step.
// One transaction is worked at a time; a finished result waits in the output register.
// Synchronous active-high reset: rate and heading to zero, limits and initial heading to defaults.
`default_nettype none
module angular_rate_ramp_limiter_core
   import arrl_pkg::*;
#(
   parameter int RATE_WIDTH = 18
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic        [MODE_WIDTH-1:0]    req_mode,
   input  wire logic signed [RATE_WIDTH-1:0]    req_requested_rate,
   input  wire logic        [TIME_WIDTH-1:0]    req_tick_time,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      signed [RATE_WIDTH-1:0]    rsp_angular_rate,
   output logic      signed [RATE_WIDTH-1:0]    rsp_heading_now,
   input  wire logic                            csr_write_enable,
   input  wire logic        [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic        [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int MW = ((RATE_WIDTH > LIMIT_WIDTH) ? RATE_WIDTH : LIMIT_WIDTH) + 1;
   localparam int PW = MW + TIME_WIDTH + 1;
   localparam int XW = ((RATE_WIDTH > LIMIT_WIDTH + 1) ? RATE_WIDTH : LIMIT_WIDTH + 1) + 2;

   localparam logic signed [XW-1:0] SAT_HI =
      {{(XW-RATE_WIDTH+1){1'b0}}, {(RATE_WIDTH-1){1'b1}}};
   localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [XW-1:0] PI_X     = XW'(PI_Q);
   localparam logic signed [XW-1:0] TWO_PI_X = XW'(TWO_PI_Q);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INC,
      S_RAMP,
      S_HMUL,
      S_HEAD,
      S_DONE
   } state_type;

   function automatic logic signed [RATE_WIDTH-1:0] sat_w(input logic signed [XW-1:0] x);
      logic signed [XW-1:0] y;
      begin
         y = x;
         if (x > SAT_HI) begin
            y = SAT_HI;
         end else if (x < SAT_LO) begin
            y = SAT_LO;
         end
         return y[RATE_WIDTH-1:0];
      end
   endfunction

   state_type state_ff;

   logic        [LIMIT_WIDTH-1:0]   max_rate_ff;
   logic        [LIMIT_WIDTH-1:0]   max_accel_ff;
   logic signed [HEADING_WIDTH-1:0] init_heading_ff;

   logic signed [RATE_WIDTH-1:0] rate_ff;
   logic signed [RATE_WIDTH-1:0] rate_in;
   logic signed [RATE_WIDTH-1:0] heading_ff;
   logic signed [RATE_WIDTH-1:0] heading_in;
   logic signed [RATE_WIDTH-1:0] restart_heading;
   logic                         rsp_valid_ff;
   logic signed [RATE_WIDTH-1:0] rsp_rate_ff;
   logic signed [RATE_WIDTH-1:0] rsp_heading_ff;

   logic signed [RATE_WIDTH-1:0] req_rate_ff;
   logic        [TIME_WIDTH-1:0] tick_ff;

   logic signed [XW-1:0] cmag_ff, cmag_in;
   logic signed [XW-1:0] rmag_ff, rmag_in;
   logic cneg_ff, cneg_in, cpos_ff, cpos_in;
   logic dneg_ff, dneg_in, dpos_ff, dpos_in;

   logic                  mul_en;
   logic signed [MW-1:0]  mul_a;
   logic signed [PW-1:0]  prod;
   logic                  out_load;
   logic                  req_take;

   // --- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff     <= MAX_RATE_RESET;
         max_accel_ff    <= MAX_ACCEL_RESET;
         init_heading_ff <= INIT_HEADING_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_RATE:     max_rate_ff     <= csr_write_data[LIMIT_WIDTH-1:0];
            CSR_MAX_ACCEL:    max_accel_ff    <= csr_write_data[LIMIT_WIDTH-1:0];
            CSR_INIT_HEADING: init_heading_ff <= csr_write_data[HEADING_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // --- shared multiplier
   assign mul_en = (state_ff == S_INC) || (state_ff == S_HMUL);
   assign mul_a  = (state_ff == S_HMUL) ?
                   {{(MW-RATE_WIDTH){rate_ff[RATE_WIDTH-1]}}, rate_ff} :
                   {{(MW-LIMIT_WIDTH){1'b0}}, max_accel_ff};

   arrl_mul #(
      .A_WIDTH (MW)
   ) u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (tick_ff),
      .product (prod)
   );

   // --- magnitudes and directions, taken while accel * time is multiplied
   always_comb begin
      logic signed [XW-1:0] rate_x;
      logic signed [XW-1:0] req_x;
      logic signed [XW-1:0] rabs;
      logic signed [XW-1:0] maxr_x;
      rate_x  = {{(XW-RATE_WIDTH){rate_ff[RATE_WIDTH-1]}}, rate_ff};
      req_x   = {{(XW-RATE_WIDTH){req_rate_ff[RATE_WIDTH-1]}}, req_rate_ff};
      maxr_x  = {{(XW-LIMIT_WIDTH){1'b0}}, max_rate_ff};
      cmag_in = rate_ff[RATE_WIDTH-1] ? -rate_x : rate_x;
      rabs    = req_rate_ff[RATE_WIDTH-1] ? -req_x : req_x;
      rmag_in = (rabs > maxr_x) ? maxr_x : rabs;
      cneg_in = rate_ff[RATE_WIDTH-1];
      cpos_in = !rate_ff[RATE_WIDTH-1] && (rate_ff != '0);
      // zero request keeps the current direction
      if (rmag_in == '0) begin
         dneg_in = cneg_in;
         dpos_in = cpos_in;
      end else begin
         dneg_in = req_rate_ff[RATE_WIDTH-1];
         dpos_in = !req_rate_ff[RATE_WIDTH-1];
      end
   end

   // --- ramp step
   always_comb begin
      logic signed [XW-1:0] inc_x;
      logic signed [XW-1:0] sum_x;
      logic signed [XW-1:0] dif_x;
      logic signed [XW-1:0] adj_x;
      logic signed [XW-1:0] val_x;
      logic                 opp;
      logic                 neg;
      logic                 zero;
      inc_x = {{(XW-LIMIT_WIDTH){1'b0}}, prod[TIME_WIDTH +: LIMIT_WIDTH]};
      sum_x = cmag_ff + inc_x;
      dif_x = cmag_ff - inc_x;
      opp   = (cpos_ff && dneg_ff) || (cneg_ff && dpos_ff);
      adj_x = cmag_ff;
      neg   = dneg_ff;
      zero  = !dneg_ff && !dpos_ff;
      if (!opp) begin
         if (sum_x < rmag_ff) begin
            adj_x = sum_x;
         end else if (dif_x > rmag_ff) begin
            adj_x = dif_x;
         end else if ((cmag_ff - rmag_ff < inc_x) && (rmag_ff - cmag_ff < inc_x)) begin
            adj_x = rmag_ff;
         end
      end else if (cmag_ff + rmag_ff < inc_x) begin
         adj_x = rmag_ff;
      end else begin
         // decelerate in the old direction; may pass through zero
         adj_x = dif_x;
         neg   = cneg_ff;
         zero  = !cneg_ff && !cpos_ff;
      end
      if (zero) begin
         val_x = '0;
      end else if (neg) begin
         val_x = -adj_x;
      end else begin
         val_x = adj_x;
      end
      rate_in = sat_w(val_x);
   end

   // --- heading integration with a single wrap
   always_comb begin
      logic signed [XW-1:0] delta_x;
      logic signed [XW-1:0] head_x;
      logic signed [XW-1:0] h_x;
      logic signed [XW-1:0] init_x;
      delta_x = XW'(prod >>> TIME_WIDTH);
      head_x  = {{(XW-RATE_WIDTH){heading_ff[RATE_WIDTH-1]}}, heading_ff};
      h_x     = head_x + delta_x;
      if (h_x > PI_X) begin
         h_x = h_x - TWO_PI_X;
      end else if (h_x < -PI_X) begin
         h_x = h_x + TWO_PI_X;
      end
      heading_in = sat_w(h_x);
      init_x = {{(XW-HEADING_WIDTH){init_heading_ff[HEADING_WIDTH-1]}}, init_heading_ff};
      restart_heading = sat_w(init_x);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // --- sequencer and kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  case (req_mode)
                     MODE_RAMP: begin
                        state_ff <= S_INC;
                     end
                     MODE_RESTART: begin
                        rate_ff    <= '0;
                        heading_ff <= restart_heading;
                        state_ff   <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_INC: begin
               state_ff <= S_RAMP;
            end
            S_RAMP: begin
               rate_ff  <= rate_in;
               state_ff <= S_HMUL;
            end
            S_HMUL: begin
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               heading_ff <= heading_in;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // --- payload capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_rate_ff <= req_requested_rate;
         tick_ff     <= req_tick_time;
      end
      if (state_ff == S_INC) begin
         cmag_ff <= cmag_in;
         rmag_ff <= rmag_in;
         cneg_ff <= cneg_in;
         cpos_ff <= cpos_in;
         dneg_ff <= dneg_in;
         dpos_ff <= dpos_in;
      end
      if (out_load) begin
         rsp_rate_ff    <= rate_ff;
         rsp_heading_ff <= heading_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angular_rate = rsp_rate_ff;
   assign rsp_heading_now  = rsp_heading_ff;

   a_ramp_after_inc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RAMP) |-> ($past(state_ff) == S_INC))
      else $error("ramp step entered without multiplier pass");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_mode == MODE_RESTART)) |=> (rate_ff == '0))
      else $error("restart did not clear the rate");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("second transaction taken while busy");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid && (rsp_angular_rate == $past(rate_ff))
                    && (rsp_heading_now == $past(heading_ff))))
      else $error("result register not loaded from kept state");

endmodule
`default_nettype wire

// ===== hdl/arrl_mul.sv =====
// Shared registered multiplier: signed operand times unsigned tick time.
`default_nettype none
module arrl_mul
   import arrl_pkg::*;
#(
   parameter int A_WIDTH = 19
) (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic signed [A_WIDTH-1:0]           op_a,
   input  wire logic        [TIME_WIDTH-1:0]        op_b,
   output logic      signed [A_WIDTH+TIME_WIDTH:0]  product
);

   logic signed [A_WIDTH+TIME_WIDTH:0] prod_ff;
   logic signed [A_WIDTH+TIME_WIDTH:0] prod_in;

   assign prod_in = op_a * signed'({1'b0, op_b});

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the angular rate ramp limiter core.
`timescale 1ns / 100ps

module tb;
   import arrl_pkg::*;

   localparam int RATE_W = 18;
   localparam longint RATE_TOP = (64'sd1 <<< (RATE_W - 1)) - 1;
   localparam longint RATE_BOTTOM = -RATE_TOP - 1;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int LATENCY_SLACK = 12;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      logic signed [RATE_W-1:0] heading;
   } turn_type;

   typedef enum int {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PATTERN} drain_style_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid;
   logic                              req_ready;
   logic        [MODE_WIDTH-1:0]      req_mode;
   logic signed [RATE_W-1:0]          req_requested_rate;
   logic        [TIME_WIDTH-1:0]      req_tick_time;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [RATE_W-1:0]          rsp_angular_rate;
   logic signed [RATE_W-1:0]          rsp_heading_now;
   logic                              csr_write_enable;
   logic        [CSR_INDEX_WIDTH-1:0] csr_index;
   logic        [CSR_DATA_WIDTH-1:0]  csr_write_data;

   // predictor state and its copy of the limits
   longint kept_rate;
   longint kept_heading;
   longint lim_rate;
   longint lim_accel;
   longint home_heading;
   turn_type turns_due[$];
   turn_type arrived_due;
   int     mismatch_count = 0;

   // traffic shaping
   drain_style_type drain_style = DRAIN_FREE;
   int           hold_left = 0;
   int           stall_phase = 0;
   int           burst_left = 0;
   bit           steady_sender = 1'b1;

   angular_rate_ramp_limiter_core #(.RATE_WIDTH(RATE_W)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_requested_rate (req_requested_rate),
      .req_tick_time      (req_tick_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_angular_rate   (rsp_angular_rate),
      .rsp_heading_now    (rsp_heading_now),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint clamp_rate(input longint x);
      if (x > RATE_TOP) return RATE_TOP;
      if (x < RATE_BOTTOM) return RATE_BOTTOM;
      return x;
   endfunction

   function automatic longint sign_of(input longint x);
      return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
   endfunction

   // Work out the next rate and heading for one accepted transaction.
   function automatic void advance_turn(input logic [MODE_WIDTH-1:0] mode,
                                        input logic signed [RATE_W-1:0] req,
                                        input logic [TIME_WIDTH-1:0] dt);
      longint rq, t, cmag, cdir, rmag, dir, inc, adj, h;
      turn_type due;
      rq = req;
      t = dt;
      if (mode == MODE_RESTART) begin
         kept_rate = 0;
         kept_heading = clamp_rate(home_heading);
      end else if (mode == MODE_RAMP) begin
         cmag = (kept_rate < 0) ? -kept_rate : kept_rate;
         cdir = sign_of(kept_rate);
         rmag = (rq < 0) ? -rq : rq;
         dir = sign_of(rq);
         inc = (lim_accel * t) >> 16;
         adj = cmag;
         if (rmag > lim_rate) rmag = lim_rate;
         // zero request keeps the current direction
         if (rmag == 0) dir = cdir;
         if (cdir * dir >= 0) begin
            if (cmag + inc < rmag) adj = cmag + inc;
            else if (cmag - inc > rmag) adj = cmag - inc;
            else if (((cmag > rmag) ? cmag - rmag : rmag - cmag) < inc) adj = rmag;
         end else if (cmag + rmag < inc) begin
            adj = rmag;
         end else begin
            // decelerate in the old sign; may cross zero
            adj = cmag - inc;
            dir = cdir;
         end
         kept_rate = clamp_rate(dir * adj);
         h = kept_heading + ((kept_rate * t) >>> 16);
         if (h > PI_Q) h -= TWO_PI_Q;
         else if (h < -PI_Q) h += TWO_PI_Q;
         kept_heading = clamp_rate(h);
      end
      due.rate = kept_rate[RATE_W-1:0];
      due.heading = kept_heading[RATE_W-1:0];
      turns_due.push_back(due);
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Scoreboard: config shadow, result check, prediction on accepted input.
   always @(posedge clock) begin
      if (reset) begin
         kept_rate = 0;
         kept_heading = 0;
         lim_rate = MAX_RATE_RESET;
         lim_accel = MAX_ACCEL_RESET;
         home_heading = $signed(INIT_HEADING_RESET);
         turns_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_RATE:     lim_rate = csr_write_data[LIMIT_WIDTH-1:0];
               CSR_MAX_ACCEL:    lim_accel = csr_write_data[LIMIT_WIDTH-1:0];
               CSR_INIT_HEADING: home_heading = $signed(csr_write_data[HEADING_WIDTH-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (turns_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual rate %0d heading %0d",
                        $time, rsp_angular_rate, rsp_heading_now);
               mismatch_count++;
            end else begin
               arrived_due = turns_due.pop_front();
               check_field("angular_rate", arrived_due.rate, rsp_angular_rate);
               check_field("heading_now", arrived_due.heading, rsp_heading_now);
            end
         end
         if (req_valid && req_ready)
            advance_turn(req_mode, req_requested_rate, req_tick_time);
      end
   end

   // Result side stalls: long hold-off first, then the current pattern.
   always @(negedge clock) begin
      stall_phase++;
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         case (drain_style)
            DRAIN_FREE:   rsp_ready = 1'b1;
            DRAIN_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
            default:      rsp_ready = ((stall_phase % 7) inside {0, 1, 3, 4, 5});
         endcase
      end
   end

   task automatic send_item(input logic [MODE_WIDTH-1:0] mode,
                            input logic signed [RATE_W-1:0] rate,
                            input logic [TIME_WIDTH-1:0] dt);
      int gap;
      if (!steady_sender && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_valid = 1'b1;
      req_mode = mode;
      req_requested_rate = rate;
      req_tick_time = dt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected result is back.
   task automatic wait_all_results();
      req_valid = 1'b0;
      while (turns_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_limits(input logic [LIMIT_WIDTH-1:0] max_rate,
                             input logic [LIMIT_WIDTH-1:0] max_accel,
                             input logic signed [HEADING_WIDTH-1:0] start_heading);
      logic [31:0] noise;
      noise = $urandom;
      wait_all_results();
      write_csr(CSR_MAX_RATE, max_rate);
      write_csr(CSR_MAX_ACCEL, max_accel);
      // upper data bits are don't-care for the heading register
      write_csr(CSR_INIT_HEADING, {noise[1:0], start_heading});
   endtask

   function automatic logic signed [RATE_W-1:0] pick_target();
      logic [31:0] raw;
      longint v;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = $urandom_range(0, 1) ? RATE_TOP : RATE_BOTTOM;
         2, 3: v = $signed(raw[RATE_W-1:0]);
         default: begin
            v = $urandom_range(0, lim_rate + 16);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v[RATE_W-1:0];
   endfunction

   function automatic logic [TIME_WIDTH-1:0] pick_dt(input int scale);
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return TIME_WIDTH'($urandom);
         default: return TIME_WIDTH'($urandom_range(1, scale));
      endcase
   endfunction

   function automatic logic [LIMIT_WIDTH-1:0] pick_limit(input int typical);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return LIMIT_WIDTH'(typical);
         default: return LIMIT_WIDTH'($urandom_range(1, 131071));
      endcase
   endfunction

   task automatic test_power_on_state();
      send_item(MODE_HOLD, 18'sd777, 16'd500);
      send_item(MODE_RAMP, RATE_TOP[RATE_W-1:0], 16'hFFFF);
      send_item(MODE_RAMP, 18'sd0, 16'd1000);
      send_item(MODE_RAMP, RATE_BOTTOM[RATE_W-1:0], 16'hFFFF);
      send_item(MODE_SPARE, -18'sd5, 16'd9);
      send_item(MODE_RESTART, 18'sd123, 16'd77);
      send_item(MODE_RAMP, 18'sd0, 16'd0);
   endtask

   task automatic test_ramp_corners();
      // rate limit of zero turns any request into a zero request
      set_limits(17'd0, 17'd25736, 15'sd0);
      send_item(MODE_RAMP, 18'sd5000, 16'd3000);
      // widest limits, then drive heading past a single wrap both ways
      set_limits(17'h1FFFF, 17'h1FFFF, 15'sd16383);
      send_item(MODE_RESTART, 18'sd0, 16'd0);
      repeat (4) send_item(MODE_RAMP, RATE_TOP[RATE_W-1:0], 16'hFFFF);
      set_limits(17'h1FFFF, 17'h1FFFF, -15'sd16384);
      send_item(MODE_RESTART, 18'sd0, 16'd0);
      repeat (4) send_item(MODE_RAMP, RATE_BOTTOM[RATE_W-1:0], 16'hFFFF);
      // increment 299 per tick at dt 150
      send_item(MODE_RESTART, 18'sd0, 16'd0);
      send_item(MODE_RAMP, 18'sd299, 16'd150);
      send_item(MODE_RAMP, 18'sd100, 16'd150);
      send_item(MODE_RAMP, -18'sd500, 16'd150);
      send_item(MODE_RAMP, 18'sd50, 16'd150);
      send_item(MODE_RAMP, 18'sd40000, 16'd150);
      send_item(MODE_RAMP, 18'sd0, 16'd150);
   endtask

   // Well-formed motion: hold a target for a stretch of ticks, with some noise.
   task automatic drive_motion(input int count);
      int sent, run, scale, pick;
      logic signed [RATE_W-1:0] target;
      logic [31:0] raw;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         raw = $urandom;
         if (pick < 5) begin
            send_item(MODE_RESTART, raw[RATE_W-1:0], raw[31:16]);
            sent++;
         end else if (pick < 9) begin
            send_item(MODE_HOLD, raw[RATE_W-1:0], raw[31:16]);
            sent++;
         end else if (pick < 11) begin
            send_item(MODE_SPARE, raw[RATE_W-1:0], raw[31:16]);
            sent++;
         end else if (pick < 15) begin
            send_item(MODE_RAMP, raw[RATE_W-1:0], TIME_WIDTH'($urandom));
            sent++;
         end else begin
            target = pick_target();
            run = $urandom_range(1, 30);
            scale = $urandom_range(0, 1) ? 512 : 8192;
            repeat (run) begin
               send_item(MODE_RAMP, target, pick_dt(scale));
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_motion();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_limits(17'h1FFFF, 17'h1FFFF, 15'sd12868);
            1: set_limits(17'd0, 17'd0, -15'sd12868);
            2: set_limits(MAX_RATE_RESET, MAX_ACCEL_RESET, 15'sd0);
            3: begin
               set_limits(17'd1, 17'd1, 15'sd16383);
               write_csr(CSR_SPARE, CSR_DATA_WIDTH'($urandom));
            end
            default: set_limits(pick_limit(12868), pick_limit(25736),
                                HEADING_WIDTH'($urandom));
         endcase
         drain_style = drain_style_type'(phase % 3);
         steady_sender = (phase % 4 == 0);
         drive_motion((phase == 1) ? 100 : 250);
      end
   endtask

   task automatic test_backpressure_fill();
      set_limits(MAX_RATE_RESET, MAX_ACCEL_RESET, 15'sd100);
      drain_style = DRAIN_FREE;
      steady_sender = 1'b1;
      hold_left = 150;
      drive_motion(40);
      steady_sender = 1'b0;
      drain_style = DRAIN_RANDOM;
      hold_left = 80;
      drive_motion(30);
   endtask

   task automatic test_pause_to_empty();
      drain_style = DRAIN_PATTERN;
      steady_sender = 1'b0;
      drive_motion(20);
      wait_all_results();
      drive_motion(20);
   endtask

   initial begin
      req_valid = 1'b0;
      req_mode = MODE_RAMP;
      req_requested_rate = '0;
      req_tick_time = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_MAX_RATE;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_on_state();
      test_ramp_corners();
      test_random_motion();
      test_backpressure_fill();
      test_pause_to_empty();

      wait_all_results();
      drain_style = DRAIN_FREE;
      repeat (LATENCY_SLACK) @(posedge clock);
      if (mismatch_count == 0 && turns_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
